@@ hw/rtl/tdhl_pkg.sv @@
package tdhl_pkg;

   typedef struct packed {
      logic [8:0] x;
      logic [8:0] y;
      logic [8:0] w;
      logic [8:0] h;
   } box_type;

   localparam box_type BOX_UP     = '{x: 9'd42,  y: 9'd215, w: 9'd36, h: 9'd30};
   localparam box_type BOX_DOWN   = '{x: 9'd42,  y: 9'd277, w: 9'd36, h: 9'd30};
   localparam box_type BOX_LEFT   = '{x: 9'd6,   y: 9'd246, w: 9'd30, h: 9'd36};
   localparam box_type BOX_RIGHT  = '{x: 9'd84,  y: 9'd246, w: 9'd30, h: 9'd36};
   localparam box_type BOX_A      = '{x: 9'd145, y: 9'd220, w: 9'd64, h: 9'd40};
   localparam box_type BOX_B      = '{x: 9'd145, y: 9'd268, w: 9'd64, h: 9'd40};
   localparam box_type BOX_SELECT = '{x: 9'd116, y: 9'd248, w: 9'd26, h: 9'd34};

   // d-pad bounding box and its center
   localparam logic [8:0] PAD_LEFT_EDGE   = BOX_LEFT.x;
   localparam logic [8:0] PAD_RIGHT_EDGE  = BOX_RIGHT.x + BOX_RIGHT.w;
   localparam logic [8:0] PAD_TOP_EDGE    = BOX_UP.y;
   localparam logic [8:0] PAD_BOTTOM_EDGE = BOX_DOWN.y + BOX_DOWN.h;
   localparam logic [8:0] DPAD_CX    = 9'((PAD_LEFT_EDGE + PAD_RIGHT_EDGE) / 2);
   localparam logic [8:0] DPAD_CY    = 9'((PAD_TOP_EDGE + PAD_BOTTOM_EDGE) / 2);

   // direction mask bit positions
   localparam int DIR_UP_BIT    = 0;
   localparam int DIR_DOWN_BIT  = 1;
   localparam int DIR_LEFT_BIT  = 2;
   localparam int DIR_RIGHT_BIT = 3;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AREA_TOP        = 2'd0,
      CSR_HOLD_TOUCHING   = 2'd1,
      CSR_HOLD_RELEASED   = 2'd2,
      CSR_DEAD_ZONE       = 2'd3
   } csr_index_type;

   localparam logic [8:0] AREA_TOP_RESET      = 9'd208;
   localparam logic [7:0] HOLD_TOUCHING_RESET = 8'd40;
   localparam logic [7:0] HOLD_RELEASED_RESET = 8'd20;
   localparam logic [5:0] DEAD_ZONE_RESET     = 6'd6;

   // live hits for one sample
   typedef struct packed {
      logic [3:0] dir;
      logic       a;
      logic       b;
      logic       sel;
   } hit_type;

endpackage

@@ hw/rtl/tdhl_hit_test.sv @@
module tdhl_hit_test
   import tdhl_pkg::*;
#(
   parameter int COORD_BITS = 9
) (
   input  logic                  touch_valid,
   input  logic [COORD_BITS-1:0] touch_x,
   input  logic [COORD_BITS-1:0] touch_y,
   input  logic [8:0]            area_top,
   input  logic [5:0]            dead_zone,
   output hit_type               hit
);

   function automatic logic in_box(input logic [COORD_BITS-1:0] px,
                                   input logic [COORD_BITS-1:0] py,
                                   input box_type r);
      logic [COORD_BITS-1:0] x0, x1, y0, y1;
      x0 = COORD_BITS'(r.x);
      x1 = COORD_BITS'(r.x) + COORD_BITS'(r.w);
      y0 = COORD_BITS'(r.y);
      y1 = COORD_BITS'(r.y) + COORD_BITS'(r.h);
      return (px >= x0) && (px < x1) && (py >= y0) && (py < y1);
   endfunction

   localparam logic [COORD_BITS-1:0] CX = COORD_BITS'(DPAD_CX);
   localparam logic [COORD_BITS-1:0] CY = COORD_BITS'(DPAD_CY);

   logic                  active;
   logic                  in_dpad;
   logic                  dx_neg;
   logic                  dy_neg;
   logic [COORD_BITS-1:0] adx_full;
   logic [COORD_BITS-1:0] ady_full;
   logic [5:0]            adx;
   logic [5:0]            ady;
   logic [5:0]            dom;
   logic [4:0]            half;
   logic [3:0]            dir;

   always_comb begin
      active  = touch_valid && (COORD_BITS'(area_top) <= touch_y);
      in_dpad = (touch_x >= COORD_BITS'(PAD_LEFT_EDGE)) &&
                (touch_x < COORD_BITS'(PAD_RIGHT_EDGE)) &&
                (touch_y >= COORD_BITS'(PAD_TOP_EDGE)) &&
                (touch_y < COORD_BITS'(PAD_BOTTOM_EDGE));
      dx_neg   = touch_x < CX;
      dy_neg   = touch_y < CY;
      adx_full = dx_neg ? CX - touch_x : touch_x - CX;
      ady_full = dy_neg ? CY - touch_y : touch_y - CY;
      // inside the d-pad box both offsets stay below 64
      adx  = adx_full[5:0];
      ady  = ady_full[5:0];
      dom  = (adx > ady) ? adx : ady;
      half = dom[5:1];
      dir  = '0;
      if (active && in_dpad && (dom > dead_zone)) begin
         if (adx >= {1'b0, half}) begin
            if (dx_neg) begin
               dir[DIR_LEFT_BIT] = 1'b1;
            end else begin
               dir[DIR_RIGHT_BIT] = 1'b1;
            end
         end
         if (ady >= {1'b0, half}) begin
            if (dy_neg) begin
               dir[DIR_UP_BIT] = 1'b1;
            end else begin
               dir[DIR_DOWN_BIT] = 1'b1;
            end
         end
      end
      hit.dir = dir;
      hit.a   = active && in_box(touch_x, touch_y, BOX_A);
      hit.b   = active && in_box(touch_x, touch_y, BOX_B);
      hit.sel = active && in_box(touch_x, touch_y, BOX_SELECT);
   end

endmodule

@@ hw/rtl/touch_dpad_hit_test_latch.sv @@
// Touch d-pad hit test and latch. Each req transaction carries one touch sample (valid flag,
// x, y, millisecond time); each produces exactly one rsp transaction with the latched
// up/down/left/right, A, B, select and any-pressed bits. A sample passes through an input
// register, one pass of hit-test and latch logic, and a result register; one sample per cycle
// sustained, limited only by rsp_tready. Direction and button latches hold through dropouts
// shorter than the touching or released grace window; time differences wrap modulo
// 2^TIME_BITS and a button stamp of zero reads as unset.
module touch_dpad_hit_test_latch
   import tdhl_pkg::*;
#(
   parameter int COORD_BITS = 9,
   parameter int TIME_BITS  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // touch_valid, touch_x, touch_y, time_ms
   input  logic [((1 + 2*COORD_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // dir_up, dir_down, dir_left, dir_right, button_a, button_b, button_select, any_pressed
   output logic [7:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int X_LSB = 1;
   localparam int Y_LSB = X_LSB + COORD_BITS;
   localparam int T_LSB = Y_LSB + COORD_BITS;

   logic [8:0] area_top_ff;
   logic [7:0] hold_touch_ff;
   logic [7:0] hold_release_ff;
   logic [5:0] dead_zone_ff;

   logic                  in_valid_ff;
   logic                  touch_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [TIME_BITS-1:0]  time_ff;

   logic [3:0]           held_dir_ff, held_dir_in;
   logic [TIME_BITS-1:0] dir_stamp_ff, dir_stamp_in;
   logic [TIME_BITS-1:0] a_stamp_ff, a_stamp_in;
   logic [TIME_BITS-1:0] b_stamp_ff, b_stamp_in;
   logic [TIME_BITS-1:0] sel_stamp_ff, sel_stamp_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic           advance;
   hit_type        hit;
   logic [TIME_BITS-1:0] grace;
   logic [3:0]     dir_out;
   logic           a_out, b_out, sel_out;

   function automatic logic in_window(input logic [TIME_BITS-1:0] now,
                                      input logic [TIME_BITS-1:0] stamp,
                                      input logic [TIME_BITS-1:0] win);
      logic [TIME_BITS-1:0] diff;
      diff = now - stamp;
      return diff < win;
   endfunction

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_top_ff     <= AREA_TOP_RESET;
         hold_touch_ff   <= HOLD_TOUCHING_RESET;
         hold_release_ff <= HOLD_RELEASED_RESET;
         dead_zone_ff    <= DEAD_ZONE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AREA_TOP:      area_top_ff     <= csr_wdata[8:0];
            CSR_HOLD_TOUCHING: hold_touch_ff   <= csr_wdata[7:0];
            CSR_HOLD_RELEASED: hold_release_ff <= csr_wdata[7:0];
            CSR_DEAD_ZONE:     dead_zone_ff    <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         touch_ff <= req_tdata[0];
         x_ff     <= req_tdata[X_LSB +: COORD_BITS];
         y_ff     <= req_tdata[Y_LSB +: COORD_BITS];
         time_ff  <= req_tdata[T_LSB +: TIME_BITS];
      end
   end

   tdhl_hit_test #(
      .COORD_BITS(COORD_BITS)
   ) u_hit (
      .touch_valid(touch_ff),
      .touch_x    (x_ff),
      .touch_y    (y_ff),
      .area_top   (area_top_ff),
      .dead_zone  (dead_zone_ff),
      .hit        (hit)
   );

   always_comb begin
      grace = touch_ff ? TIME_BITS'(hold_touch_ff) : TIME_BITS'(hold_release_ff);

      held_dir_in  = held_dir_ff;
      dir_stamp_in = dir_stamp_ff;
      if (hit.dir != 4'd0) begin
         held_dir_in  = hit.dir;
         dir_stamp_in = time_ff;
         dir_out      = hit.dir;
      end else if ((held_dir_ff != 4'd0) && in_window(time_ff, dir_stamp_ff, grace)) begin
         dir_out = held_dir_ff;
      end else begin
         held_dir_in = 4'd0;
         dir_out     = 4'd0;
      end

      // button stamps: live press restamps, zero stamp means unset
      a_out = hit.a || ((a_stamp_ff != '0) && in_window(time_ff, a_stamp_ff, grace));
      a_stamp_in = hit.a ? time_ff : (a_out ? a_stamp_ff : '0);
      b_out = hit.b || ((b_stamp_ff != '0) && in_window(time_ff, b_stamp_ff, grace));
      b_stamp_in = hit.b ? time_ff : (b_out ? b_stamp_ff : '0);
      sel_out = hit.sel || ((sel_stamp_ff != '0) && in_window(time_ff, sel_stamp_ff, grace));
      sel_stamp_in = hit.sel ? time_ff : (sel_out ? sel_stamp_ff : '0);

      rsp_data_in = {(dir_out != 4'd0) || a_out || b_out || sel_out,
                     sel_out, b_out, a_out,
                     dir_out[DIR_RIGHT_BIT], dir_out[DIR_LEFT_BIT],
                     dir_out[DIR_DOWN_BIT], dir_out[DIR_UP_BIT]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_dir_ff  <= '0;
         dir_stamp_ff <= '0;
         a_stamp_ff   <= '0;
         b_stamp_ff   <= '0;
         sel_stamp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            held_dir_ff  <= held_dir_in;
            dir_stamp_ff <= dir_stamp_in;
            a_stamp_ff   <= a_stamp_in;
            b_stamp_ff   <= b_stamp_in;
            sel_stamp_ff <= sel_stamp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ verif/touch_dpad_hit_test_latch_tb.sv @@
`timescale 1ns / 1ps

module touch_dpad_hit_test_latch_tb;
   import tdhl_pkg::*;

   localparam int REQ_BITS    = ((1 + 2*9 + 32 + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_CAP   = 40;

   typedef enum int {
      AIM_DPAD,
      AIM_A,
      AIM_B,
      AIM_SELECT,
      AIM_ANYWHERE
   } aim_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // touch_valid, touch_x, touch_y, time_ms
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // dir_up, dir_down, dir_left, dir_right, button_a, button_b, button_select, any_pressed
   logic [7:0]                rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   touch_dpad_hit_test_latch u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow of the block's settings and latches
   logic [8:0]  top_row       = AREA_TOP_RESET;
   logic [7:0]  grace_touch   = HOLD_TOUCHING_RESET;
   logic [7:0]  grace_release = HOLD_RELEASED_RESET;
   logic [5:0]  dead_zone     = DEAD_ZONE_RESET;
   logic [3:0]  held_dir      = '0;
   logic [31:0] dir_stamp     = '0;
   logic [31:0] a_stamp       = '0;
   logic [31:0] b_stamp       = '0;
   logic [31:0] sel_stamp     = '0;

   logic [7:0]  pad_results_due[$];
   int          mismatches = 0;
   int unsigned cycle_count = 0;

   // traffic shaping
   logic        tx_gaps_on = 1'b1;
   logic        rx_stalls_on = 1'b1;
   int          burst_left = 0;
   int          hold_off_left = 0;
   int          rx_run_left = 0;
   logic        rx_ready_phase = 1'b1;
   logic [31:0] now_ms = 32'd1;

   string field_names[8] = '{"dir_up", "dir_down", "dir_left", "dir_right",
                             "button_a", "button_b", "button_select", "any_pressed"};

   function automatic logic in_box(int x, int y, box_type r);
      return x >= int'(r.x) && x < int'(r.x) + int'(r.w) &&
             y >= int'(r.y) && y < int'(r.y) + int'(r.h);
   endfunction

   function automatic logic latch_button(input logic live, inout logic [31:0] stamp,
                                         input logic [31:0] now, input logic [7:0] grace);
      logic [31:0] age;
      age = now - stamp;
      if (live) begin
         stamp = now;
         return 1'b1;
      end
      if (stamp != 0 && age < {24'd0, grace})
         return 1'b1;
      stamp = '0;
      return 1'b0;
   endfunction

   function automatic logic [7:0] predict_pad(logic touching, logic [8:0] tx, logic [8:0] ty,
                                              logic [31:0] now);
      logic [3:0]  dir;
      logic        hit_a, hit_b, hit_sel;
      logic [7:0]  grace;
      logic [31:0] dir_age;
      int          x_min, x_max, y_min, y_max;
      int          dx, dy, adx, ady, dom, half;
      logic [7:0]  pads;
      dir     = '0;
      hit_a   = 1'b0;
      hit_b   = 1'b0;
      hit_sel = 1'b0;
      grace   = touching ? grace_touch : grace_release;
      x_min   = int'(BOX_LEFT.x);
      x_max   = int'(BOX_RIGHT.x) + int'(BOX_RIGHT.w);
      y_min   = int'(BOX_UP.y);
      y_max   = int'(BOX_DOWN.y) + int'(BOX_DOWN.h);
      if (touching && ty >= top_row) begin
         hit_a   = in_box(int'(tx), int'(ty), BOX_A);
         hit_b   = in_box(int'(tx), int'(ty), BOX_B);
         hit_sel = in_box(int'(tx), int'(ty), BOX_SELECT);
         if (int'(tx) >= x_min && int'(tx) < x_max &&
             int'(ty) >= y_min && int'(ty) < y_max) begin
            dx  = int'(tx) - (x_min + x_max) / 2;
            dy  = int'(ty) - (y_min + y_max) / 2;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            dom = adx > ady ? adx : ady;
            if (dom > int'(dead_zone)) begin
               half = dom / 2;
               if (adx >= half) begin
                  if (dx < 0) dir[DIR_LEFT_BIT] = 1'b1;
                  else dir[DIR_RIGHT_BIT] = 1'b1;
               end
               if (ady >= half) begin
                  if (dy < 0) dir[DIR_UP_BIT] = 1'b1;
                  else dir[DIR_DOWN_BIT] = 1'b1;
               end
            end
         end
      end
      dir_age = now - dir_stamp;
      if (dir != 0) begin
         held_dir  = dir;
         dir_stamp = now;
      end else if (held_dir != 0 && dir_age < {24'd0, grace}) begin
         dir = held_dir;
      end else begin
         held_dir = '0;
      end
      hit_a   = latch_button(hit_a, a_stamp, now, grace);
      hit_b   = latch_button(hit_b, b_stamp, now, grace);
      hit_sel = latch_button(hit_sel, sel_stamp, now, grace);
      pads[0] = dir[DIR_UP_BIT];
      pads[1] = dir[DIR_DOWN_BIT];
      pads[2] = dir[DIR_LEFT_BIT];
      pads[3] = dir[DIR_RIGHT_BIT];
      pads[4] = hit_a;
      pads[5] = hit_b;
      pads[6] = hit_sel;
      pads[7] = (dir != 0) || hit_a || hit_b || hit_sel;
      return pads;
   endfunction

   // one touch sample; returns right after the accepting edge
   task automatic send_sample(logic touching, logic [8:0] x, logic [8:0] y, logic [31:0] t);
      int gap;
      @(negedge clock);
      if (tx_gaps_on && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid = 1'b1;
      req_tdata  = {5'd0, t, y, x, touching};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pad_results_due.push_back(predict_pad(touching, x, y, t));
      if (burst_left > 0) burst_left--;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pad_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_setting(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_AREA_TOP:      top_row       = value[8:0];
         CSR_HOLD_TOUCHING: grace_touch   = value[7:0];
         CSR_HOLD_RELEASED: grace_release = value[7:0];
         CSR_DEAD_ZONE:     dead_zone     = value[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic apply_settings(logic [8:0] row, logic [7:0] touch_ms, logic [7:0] release_ms,
                                 logic [5:0] zone);
      wait_idle();
      write_setting(CSR_AREA_TOP, row);
      write_setting(CSR_HOLD_TOUCHING, {1'b0, touch_ms});
      write_setting(CSR_HOLD_RELEASED, {1'b0, release_ms});
      write_setting(CSR_DEAD_ZONE, {3'd0, zone});
   endtask

   task automatic pick_point(aim_type aim, output logic [8:0] x, output logic [8:0] y);
      case (aim)
         AIM_DPAD: begin
            x = 9'($urandom_range(0, 120));
            y = 9'($urandom_range(205, 315));
         end
         AIM_A: begin
            x = 9'($urandom_range(140, 215));
            y = 9'($urandom_range(215, 265));
         end
         AIM_B: begin
            x = 9'($urandom_range(140, 215));
            y = 9'($urandom_range(262, 312));
         end
         AIM_SELECT: begin
            x = 9'($urandom_range(110, 146));
            y = 9'($urandom_range(242, 288));
         end
         default: begin
            x = 9'($urandom_range(0, 511));
            y = 9'($urandom_range(0, 511));
         end
      endcase
   endtask

   // touch strokes aimed at one control, with dropouts, plus random noise samples
   task automatic run_touch_traffic(int n_items);
      int         sent;
      int         len;
      aim_type    aim;
      logic [8:0] x, y;
      logic       touching;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 3) == 0) begin
            send_sample(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                        9'($urandom_range(0, 511)), $urandom());
            sent++;
         end else begin
            aim = aim_type'($urandom_range(0, 4));
            len = $urandom_range(3, 15);
            if ($urandom_range(0, 15) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 80);
            else if ($urandom_range(0, 31) == 0) now_ms = '0;
            repeat (len) begin
               pick_point(aim, x, y);
               touching = 1'b1;
               case ($urandom_range(0, 9))
                  0: touching = 1'b0;
                  1: y = 9'($urandom_range(0, 200));  // finger slid above the control area
                  default: ;
               endcase
               send_sample(touching, x, y, now_ms);
               now_ms += ($urandom_range(0, 5) == 0) ? $urandom_range(15, 70)
                                                     : $urandom_range(0, 12);
               sent++;
            end
            // release tail
            repeat ($urandom_range(0, 3)) begin
               send_sample(1'b0, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                           now_ms);
               now_ms += $urandom_range(0, 30);
               sent++;
            end
         end
      end
   endtask

   task automatic test_directed();
      send_sample(1'b1,  9'd60, 9'd220, 32'd1000);   // up
      send_sample(1'b1,  9'd60, 9'd300, 32'd1100);   // down
      send_sample(1'b1,  9'd10, 9'd261, 32'd1200);   // left
      send_sample(1'b1, 9'd110, 9'd261, 32'd1300);   // right
      send_sample(1'b1,  9'd90, 9'd232, 32'd1400);   // diagonal up-right
      send_sample(1'b1,  9'd67, 9'd261, 32'd1500);   // just outside dead zone
      send_sample(1'b1,  9'd66, 9'd261, 32'd1600);   // on dead zone edge
      send_sample(1'b1, 9'd150, 9'd230, 32'd1700);   // A
      send_sample(1'b1, 9'd150, 9'd280, 32'd1800);   // B
      send_sample(1'b1, 9'd120, 9'd250, 32'd1900);   // select
      // A held after release, then expires
      send_sample(1'b1, 9'd150, 9'd230, 32'd2000);
      send_sample(1'b0,   9'd0,   9'd0, 32'd2010);
      send_sample(1'b0,   9'd0,   9'd0, 32'd2025);
      // direction held through a touching dropout up to the window edge
      send_sample(1'b1,  9'd60, 9'd220, 32'd2100);
      send_sample(1'b1, 9'd300, 9'd100, 32'd2139);
      send_sample(1'b1, 9'd300, 9'd100, 32'd2140);
      // press at time zero is not held
      send_sample(1'b1, 9'd150, 9'd230, 32'd0);
      send_sample(1'b0,   9'd0,   9'd0, 32'd1);
      // hold across timestamp wrap
      send_sample(1'b1,  9'd60, 9'd300, 32'hFFFF_FFF0);
      send_sample(1'b1, 9'd511, 9'd511, 32'h0000_0005);
      send_sample(1'b1,   9'd0,   9'd0, 32'hFFFF_FFFF);
      send_sample(1'b0, 9'd511, 9'd511, 32'hFFFF_FFFF);
      send_sample(1'b1,   9'd0, 9'd511, 32'd5000);
      send_sample(1'b1, 9'd511, 9'd208, 32'd5001);
      wait_idle();
   endtask

   task automatic test_settings_sweep();
      apply_settings(9'd0, 8'd255, 8'd255, 6'd0);
      run_touch_traffic(100);
      apply_settings(9'd0, 8'd0, 8'd0, 6'd63);        // nothing held, no direction
      run_touch_traffic(100);
      apply_settings(9'd511, 8'd40, 8'd20, 6'd6);
      run_touch_traffic(80);
      repeat (2) begin
         apply_settings(9'($urandom_range(200, 320)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
         run_touch_traffic(100);
      end
      apply_settings(AREA_TOP_RESET, HOLD_TOUCHING_RESET, HOLD_RELEASED_RESET,
                     DEAD_ZONE_RESET);
   endtask

   task automatic test_touch_gestures();
      repeat (10) begin
         tx_gaps_on   = $urandom_range(0, 2) != 0;
         rx_stalls_on = $urandom_range(0, 2) != 0;
         run_touch_traffic(90);
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      wait_idle();
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_backpressure();
      logic [8:0] x, y;
      wait_idle();
      tx_gaps_on    = 1'b0;
      hold_off_left = 300;
      repeat (60) begin
         pick_point(AIM_DPAD, x, y);
         send_sample(1'b1, x, y, now_ms);
         now_ms += $urandom_range(0, 10);
      end
      wait_idle();
      tx_gaps_on = 1'b1;
      run_touch_traffic(60);
      wait_idle();
   endtask

   // receiver ready pattern: alternating ready and stall runs, or always ready with stalls off, plus long hold-offs
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_tready = 1'b0;
            hold_off_left--;
         end else if (!rx_stalls_on) begin
            rsp_tready = 1'b1;
         end else begin
            if (rx_run_left == 0) begin
               rx_ready_phase = !rx_ready_phase;
               rx_run_left = rx_ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_run_left--;
            rsp_tready = rx_ready_phase;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pad_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
               $display("%0t: unexpected transaction, actual %b", $time, rsp_tdata);
         end else begin
            want = pad_results_due.pop_front();
            for (int i = 0; i < 8; i++) begin
               if (rsp_tdata[i] !== want[i]) begin
                  mismatches++;
                  if (mismatches <= PRINT_CAP)
                     $display("%0t: %s expected %b actual %b", $time, field_names[i],
                              want[i], rsp_tdata[i]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_settings_sweep();
      test_touch_gestures();
      test_backpressure();
      wait_idle();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
